FILE: hw/rtl/grfa_pkg.sv
// shared types and codes of the grid rectangle allocator
`default_nettype none

package grfa_pkg;

    // request operation codes
    localparam logic OP_CLEAR = 1'b0;

    // response status codes
    localparam logic [1:0] STATUS_PLACED  = 2'd0;
    localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
    localparam logic [1:0] STATUS_CLEARED = 2'd2;

    // placed item count saturates here
    localparam logic [6:0] COUNT_MAX = 7'd127;

    typedef struct packed {
        logic       op;
        logic [3:0] rect_width;
        logic [3:0] rect_height;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] slot;
        logic [6:0] item_count;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic step;
        logic commit;
        logic no_room;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic fit;
        logic last;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/grfa_stream_if.sv
// valid/ready stream interface with a typed payload
`default_nettype none

interface grfa_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/grfa_ctrl.sv
// sequencing state machine of the grid rectangle allocator
`default_nettype none

module grfa_ctrl
    import grfa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_op,
    output logic         o_in_ready,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_CLEAR) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_DONE;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                priority if (i_sts.fit) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_DONE;
                end else if (i_sts.last) begin
                    o_cmd.no_room = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                // output register free or being emptied this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/grfa_datapath.sv
// occupancy bitmap, scan counters and fit check of the grid rectangle allocator
`default_nettype none

module grfa_datapath
    import grfa_pkg::*;
#(
    parameter int GRID_COLS = 8,
    parameter int GRID_ROWS = 15
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_req    i_req,
    input  wire t_dp_cmd i_cmd,
    output t_dp_sts      o_sts,
    output t_rsp         o_rsp
);

    localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int IW = (GRID_COLS * GRID_ROWS > 1) ? $clog2(GRID_COLS * GRID_ROWS) : 1;

    logic [GRID_COLS-1:0] r_map [GRID_ROWS];
    logic [3:0]           r_w;
    logic [3:0]           r_h;
    logic [CW-1:0]        r_col;
    logic [RW-1:0]        r_row;
    logic [IW-1:0]        r_idx;
    logic [6:0]           r_count;
    logic [6:0]           n_count;
    t_rsp                 r_res;
    t_rsp                 r_out;

    logic [GRID_COLS-1:0] col_mask;
    logic [GRID_ROWS-1:0] row_band;
    logic                 hit;
    logic                 col_ok;
    logic                 row_ok;
    logic                 start_free;
    logic [GRID_COLS-1:0] start_row;

    // columns covered by the rectangle at the current start column
    always_comb begin
        for (int c = 0; c < GRID_COLS; c++) begin
            col_mask[c] = (7'(c) >= 7'(r_col)) && (7'(c) < 7'(r_col) + 7'(r_w));
        end
    end

    // rows covered, and any occupied cell under the rectangle
    always_comb begin
        hit = 1'b0;
        for (int r = 0; r < GRID_ROWS; r++) begin
            row_band[r] = (7'(r) >= 7'(r_row)) && (7'(r) < 7'(r_row) + 7'(r_h));
            hit         = hit | (row_band[r] & (|(r_map[r] & col_mask)));
        end
    end

    assign col_ok     = (7'(r_col) + 7'(r_w)) <= 7'(GRID_COLS);
    assign row_ok     = (7'(r_row) + 7'(r_h)) <= 7'(GRID_ROWS);
    assign start_row  = r_map[r_row];
    assign start_free = !start_row[r_col];

    assign o_sts.fit  = start_free && col_ok && row_ok && !hit;
    assign o_sts.last = (r_row == RW'(GRID_ROWS - 1)) && (r_col == CW'(GRID_COLS - 1));

    assign n_count = (r_count != COUNT_MAX) ? r_count + 7'd1 : r_count;

    // bitmap and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < GRID_ROWS; r++) begin
                r_map[r] <= '0;
            end
            r_count <= '0;
        end else if (i_cmd.clear) begin
            for (int r = 0; r < GRID_ROWS; r++) begin
                r_map[r] <= '0;
            end
            r_count <= '0;
        end else if (i_cmd.commit) begin
            for (int r = 0; r < GRID_ROWS; r++) begin
                if (row_band[r]) begin
                    r_map[r] <= r_map[r] | col_mask;
                end
            end
            r_count <= n_count;
        end
    end

    // scan position, size, result and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w   <= i_req.rect_width;
            r_h   <= i_req.rect_height;
            r_col <= '0;
            r_row <= '0;
            r_idx <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IW'(1);
            if (r_col == CW'(GRID_COLS - 1)) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
        if (i_cmd.clear) begin
            r_res <= '{status: STATUS_CLEARED, slot: 7'd0, item_count: 7'd0};
        end else if (i_cmd.commit) begin
            r_res <= '{status: STATUS_PLACED, slot: 7'(r_idx), item_count: n_count};
        end else if (i_cmd.no_room) begin
            r_res <= '{status: STATUS_NO_ROOM, slot: 7'd0, item_count: r_count};
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_rsp = r_out;

endmodule

`default_nettype wire

FILE: hw/rtl/grid_rect_first_fit_allocator_unit.sv
// top level of the grid first-fit rectangle allocator
//
//  channel | dir | payload                               | transfer when
//  i_req   | in  | op, rect_width, rect_height           | valid & ready
//  o_rsp   | out | status, slot, item_count              | valid & ready
//
// a clear goes from idle straight to the done state, which hands its result to the output register
// a place loads the size and tries start cells in row-major order, at most GRID_ROWS*GRID_COLS,
// then goes to the done state; the next request is taken only once the unit is back in idle
// the scan tests one start cell per cycle against the whole bitmap
// reset is synchronous and clears the bitmap and the count at once; no clearing pass
// a result waiting on o_rsp does not block the next request transfer; the scan
// holds its result until the output register is free
`default_nettype none

module grid_rect_first_fit_allocator_unit
    import grfa_pkg::*;
#(
    parameter int GRID_COLS = 8,
    parameter int GRID_ROWS = 15
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    grfa_stream_if.sink    i_req,
    grfa_stream_if.source  o_rsp
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_req    req_payload;
    t_rsp    rsp_payload;

    assign req_payload = i_req.payload;

    // sequencer: idle, scan, hand result to output register
    grfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_op        (req_payload.op),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // bitmap, scan position, fit check, result and output registers
    grfa_datapath #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_payload),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .o_rsp   (rsp_payload)
    );

    assign o_rsp.payload = rsp_payload;

endmodule

`default_nettype wire

FILE: hw/rtl/grfa_checker.sv
// port-level checks of the grid rectangle allocator and their binding
`default_nettype none

module grfa_checker
    import grfa_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_rsp_valid,
    input wire logic i_rsp_ready,
    input wire t_rsp i_rsp
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("result changed while stalled");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    // a clear reports an empty map
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.status == STATUS_CLEARED |->
            i_rsp.slot == 7'd0 && i_rsp.item_count == 7'd0)
        else $error("clear result not zero");

    // a placement always counts at least one item
    a_placed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.status == STATUS_PLACED |-> i_rsp.item_count != 7'd0)
        else $error("placed result with zero count");

endmodule

bind grid_rect_first_fit_allocator_unit grfa_checker u_grfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);

`default_nettype wire

FILE: tb/sv/grid_rect_first_fit_allocator_unit_test.sv
// self-checking testbench of the grid first-fit rectangle allocator
`default_nettype none

module grid_rect_first_fit_allocator_unit_test;
    import grfa_pkg::*;

    // grid shape as built into the unit under test
    localparam int COLS = 8;
    localparam int ROWS = 15;
    localparam int CELLS = COLS * ROWS;

    // the package names only the clear code; the other value places
    localparam logic OP_PLACE = 1'b1;

    // a full scan plus the pipeline, with margin, for the closing wait
    localparam int DRAIN_CYCLES = 140;

    // one pending request with its pacing hints
    typedef struct {
        t_req req;
        bit   wait_idle;  // hold off until every result so far has come back
        bit   back2back;  // no gap after this transfer
    } t_pending_req;

    logic i_clk;
    logic i_rst_n;

    grfa_stream_if #(.t_payload(t_req)) req_if ();
    grfa_stream_if #(.t_payload(t_rsp)) rsp_if ();

    grid_rect_first_fit_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // requests still to be sent and results still to come
    t_pending_req requests_to_send[$];
    t_rsp         alloc_results_due[$];

    // shadow copy of the occupancy bitmap and the placed count
    bit [CELLS-1:0] shadow_map;
    bit [6:0]       shadow_count;

    int mismatch_count;
    int send_gap_left;
    int stall_left;
    int stall_mode;
    int monitor_cycles;

    // clock: period 8
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // synchronous reset, asserted only at the start
    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return $urandom_range(0, 3);
        end else if (roll < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // row-major first-fit placement on the shadow map; clear wipes map and count
    function automatic t_rsp first_fit_place(input t_req r);
        t_rsp rsp;
        bit   found;
        bit   clash;
        int   row;
        int   col;
        int   dr;
        int   dc;
        int   w;
        int   h;
        rsp = '0;
        if (r.op == OP_CLEAR) begin
            shadow_map   = '0;
            shadow_count = '0;
            rsp.status   = STATUS_CLEARED;
            return rsp;
        end
        w     = r.rect_width;
        h     = r.rect_height;
        found = 1'b0;
        for (row = 0; row < ROWS && !found; row++) begin
            for (col = 0; col < COLS && !found; col++) begin
                // only free start cells count, and the rectangle must stay inside
                if (!shadow_map[row*COLS+col] && col + w <= COLS && row + h <= ROWS) begin
                    clash = 1'b0;
                    for (dr = 0; dr < h; dr++) begin
                        for (dc = 0; dc < w; dc++) begin
                            if (shadow_map[(row+dr)*COLS+col+dc]) begin
                                clash = 1'b1;
                            end
                        end
                    end
                    if (!clash) begin
                        found = 1'b1;
                        for (dr = 0; dr < h; dr++) begin
                            for (dc = 0; dc < w; dc++) begin
                                shadow_map[(row+dr)*COLS+col+dc] = 1'b1;
                            end
                        end
                        // count saturates instead of wrapping
                        if (shadow_count < COUNT_MAX) begin
                            shadow_count++;
                        end
                        rsp.status = STATUS_PLACED;
                        rsp.slot   = 7'(row * COLS + col);
                    end
                end
            end
        end
        if (!found) begin
            rsp.status = STATUS_NO_ROOM;
        end
        rsp.item_count = shadow_count;
        return rsp;
    endfunction

    function automatic t_pending_req make_req(input logic op, input int w, input int h,
                                              input bit wait_idle, input bit back2back);
        t_pending_req p;
        p.req.op          = op;
        p.req.rect_width  = 4'(w);
        p.req.rect_height = 4'(h);
        p.wait_idle       = wait_idle;
        p.back2back       = back2back;
        return p;
    endfunction

    // random size, weighted to small rectangles so the map fills gradually
    function automatic int pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return $urandom_range(1, 4);
        end else if (roll < 90) begin
            return $urandom_range(1, 8);
        end
        return $urandom_range(0, 15);
    endfunction

    // request driver: a transfer is seen on the edge, its result predicted
    // right away so predictions follow transfer order
    always @(posedge i_clk) begin
        bit           took;
        t_pending_req nxt;
        if (!i_rst_n) begin
            req_if.valid  <= 1'b0;
            send_gap_left = 0;
        end else begin
            took = req_if.valid && req_if.ready;
            if (took) begin
                alloc_results_due.push_back(first_fit_place(req_if.payload));
            end
            if (req_if.valid && !took) begin
                // hold the offered request until it is taken
            end else if (send_gap_left > 0) begin
                send_gap_left--;
                req_if.valid <= 1'b0;
            end else if (requests_to_send.size() != 0 &&
                         (!requests_to_send[0].wait_idle || alloc_results_due.size() == 0)) begin
                nxt = requests_to_send.pop_front();
                req_if.payload <= nxt.req;
                req_if.valid   <= 1'b1;
                // the gap runs after this request is taken
                send_gap_left = nxt.back2back ? 0 : pick_gap();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            rsp_if.ready   <= 1'b0;
            stall_left     = 0;
            stall_mode     = 1;
            monitor_cycles = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (alloc_results_due.size() == 0) begin
                    $error("result transfer with nothing outstanding: status %0d slot %0d count %0d",
                           rsp_if.payload.status, rsp_if.payload.slot,
                           rsp_if.payload.item_count);
                    mismatch_count++;
                end else begin
                    want = alloc_results_due.pop_front();
                    if (rsp_if.payload.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status,
                               rsp_if.payload.status);
                        mismatch_count++;
                    end
                    if (rsp_if.payload.slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, rsp_if.payload.slot);
                        mismatch_count++;
                    end
                    if (rsp_if.payload.item_count !== want.item_count) begin
                        $error("item_count: expected %0d, got %0d", want.item_count,
                               rsp_if.payload.item_count);
                        mismatch_count++;
                    end
                end
            end
            // stall style is re-picked at random; mode 0 never stalls
            monitor_cycles++;
            if (monitor_cycles % 256 == 0) begin
                stall_mode = $urandom_range(0, 3);
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
                if (stall_mode != 0 && $urandom_range(0, 2) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        int  seg;
        int  k;
        int  seg_len;
        bit  calm;
        mismatch_count = 0;

        // directed: full grid, empty sizes, oversize, row and column edges
        requests_to_send.push_back(make_req(OP_CLEAR, 15, 15, 0, 0));  // sizes ignored
        requests_to_send.push_back(make_req(OP_PLACE, 8, 15, 0, 0));   // whole grid
        requests_to_send.push_back(make_req(OP_PLACE, 0, 0, 0, 1));    // no free cell left
        requests_to_send.push_back(make_req(OP_PLACE, 1, 1, 0, 1));
        requests_to_send.push_back(make_req(OP_CLEAR, 0, 0, 0, 1));
        requests_to_send.push_back(make_req(OP_PLACE, 9, 1, 0, 0));    // wider than grid
        requests_to_send.push_back(make_req(OP_PLACE, 1, 15, 0, 0));   // full column
        requests_to_send.push_back(make_req(OP_PLACE, 15, 15, 0, 0));
        requests_to_send.push_back(make_req(OP_PLACE, 0, 3, 0, 0));    // zero width
        requests_to_send.push_back(make_req(OP_PLACE, 3, 0, 0, 1));    // zero height
        requests_to_send.push_back(make_req(OP_PLACE, 7, 1, 0, 1));
        requests_to_send.push_back(make_req(OP_PLACE, 2, 2, 0, 0));
        requests_to_send.push_back(make_req(OP_PLACE, 8, 1, 0, 0));    // blocked by column
        requests_to_send.push_back(make_req(OP_PLACE, 7, 14, 0, 0));
        requests_to_send.push_back(make_req(OP_PLACE, 4, 6, 0, 0));
        requests_to_send.push_back(make_req(OP_PLACE, 1, 16 - 1, 0, 0));
        requests_to_send.push_back(make_req(OP_PLACE, 5, 10, 0, 0));
        requests_to_send.push_back(make_req(OP_PLACE, 15, 4, 0, 0));
        requests_to_send.push_back(make_req(OP_PLACE, 1, 1, 0, 1));
        requests_to_send.push_back(make_req(OP_PLACE, 8, 8, 0, 0));
        requests_to_send.push_back(make_req(OP_PLACE, 2, 1, 0, 0));
        requests_to_send.push_back(make_req(OP_PLACE, 1, 2, 0, 0));

        // sender waits for every result before the clear, then a run of empty rectangles
        // drives the count into saturation
        requests_to_send.push_back(make_req(OP_CLEAR, $urandom_range(0, 15),
                                            $urandom_range(0, 15), 1, 0));
        for (k = 0; k < 132; k++) begin
            if ($urandom_range(0, 1) == 0) begin
                requests_to_send.push_back(make_req(OP_PLACE, 0, $urandom_range(0, 15),
                                                    0, k % 40 < 20));
            end else begin
                // width kept inside the grid so every empty rectangle is counted
                requests_to_send.push_back(make_req(OP_PLACE, $urandom_range(0, 8), 0,
                                                    0, k % 40 < 20));
            end
        end
        // a real rectangle on top of the saturated count
        requests_to_send.push_back(make_req(OP_PLACE, 3, 3, 0, 0));

        // random: segments of mostly placements, some opened by a clear,
        // some sent back to back, some waiting for the unit to go idle
        for (seg = 0; seg < 21; seg++) begin
            calm    = ($urandom_range(0, 3) == 0);
            seg_len = $urandom_range(30, 50);
            if ($urandom_range(0, 2) == 0) begin
                requests_to_send.push_back(make_req(OP_CLEAR, $urandom_range(0, 15),
                                                    $urandom_range(0, 15),
                                                    $urandom_range(0, 3) == 0, calm));
            end
            for (k = 0; k < seg_len; k++) begin
                if ($urandom_range(0, 99) < 4) begin
                    requests_to_send.push_back(make_req(OP_CLEAR, $urandom_range(0, 15),
                                                        $urandom_range(0, 15), 0, calm));
                end else begin
                    requests_to_send.push_back(make_req(OP_PLACE, pick_size(), pick_size(),
                                                        0, calm));
                end
            end
        end

        // wait for the last request to go out and every result to come back
        while (requests_to_send.size() != 0 || req_if.valid || alloc_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        // let any stray result show up
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && alloc_results_due.size() == 0) begin
            $display("grid_rect_first_fit_allocator_unit: match");
        end else begin
            $display("grid_rect_first_fit_allocator_unit: mismatch");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #8000000;
        $display("grid_rect_first_fit_allocator_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
